### rtl/sasf_pkg.sv
package sasf_pkg;

    // element and coordinate sizing
    localparam int ELEMENT_BYTES = 4;
    localparam int COORD_BITS    = 16;
    localparam int DATA_W        = 32;
    localparam int CFG_W         = 16;
    localparam int NUM_AXES      = 4;
    localparam int AXIS_W        = 2;

    // compare width: holds any coordinate or register value plus one
    localparam int WIDE_W = ((COORD_BITS > CFG_W) ? COORD_BITS : CFG_W) + 1;

    // iteration counter of the remainder unit
    localparam int CNT_W = $clog2(COORD_BITS + 1);

    // apb sizing
    localparam int APB_DW = 32;
    localparam int ADDR_W = 5;

    localparam logic [DATA_W-1:0] DATA_MASK = (ELEMENT_BYTES * 8 >= DATA_W) ?
        {DATA_W{1'b1}} : DATA_W'((64'd1 << (ELEMENT_BYTES * 8)) - 64'd1);

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [CFG_W-1:0]      t_cfg;

    typedef enum logic [2:0] {
        REG_DIM_0 = 3'd0,
        REG_DIM_1 = 3'd1,
        REG_DIM_2 = 3'd2,
        REG_DIM_3 = 3'd3,
        REG_AXIS  = 3'd4,
        REG_BEGIN = 3'd5,
        REG_END   = 3'd6,
        REG_STEP  = 3'd7
    } t_reg_idx;

endpackage

### rtl/sasf_remainder.sv
module sasf_remainder import sasf_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_coord i_dividend,
    input  t_cfg   i_divisor,
    output logic   o_done,
    output t_cfg   o_rem
);

    logic             r_active;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_coord           r_num;
    t_cfg             r_div;
    t_cfg             r_rem;

    logic [CFG_W:0] trial;
    logic [CFG_W:0] n_rem;

    // one restoring step per cycle, dividend bits enter msb first
    always_comb begin
        trial = {r_rem, r_num[COORD_BITS-1]};
        n_rem = (trial >= {1'b0, r_div}) ? (trial - {1'b0, r_div}) : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_active <= 1'b1;
                r_cnt    <= '0;
                r_num    <= i_dividend;
                r_div    <= i_divisor;
                r_rem    <= '0;
            end else if (r_active) begin
                r_rem <= n_rem[CFG_W-1:0];
                r_num <= r_num << 1;
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(COORD_BITS - 1)) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    // partial remainder always below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_rem < r_div))
        else $error("partial remainder not below divisor");

endmodule

### rtl/strided_axis_slice_filter.sv
// Strided single-axis slice filter. Elements of a tensor of up to four axes come in
// row-major order on s_axis, one per item (axis 3 fastest); an element leaves on
// m_axis only when its coordinate on the sliced axis lies in [slice_begin, slice_end)
// and sits a whole number of slice_step steps past slice_begin. m_axis_tlast marks a
// kept element that was the last of its tensor; if that element is dropped no mark
// appears, but the coordinates still wrap to zero. A lower rank is set by writing 1
// to the leading dim sizes; a size or step of 0 acts as 1, and end not above begin
// keeps nothing. Throughput is one item per clock while m_axis drains and no phase
// rebuild runs; a kept item is registered on its way to m_axis, while coordinates and
// the step phase advance by short counter logic between the state registers and the
// output register. Every APB write restarts the step phase: a bit-serial remainder
// unit rebuilds it; s_axis_tready stays low until it is loaded. Registers sit at byte
// addresses 4*i: dim_size_0..3, sliced axis select, slice_begin, slice_end, slice_step.
module strided_axis_slice_filter import sasf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,

    // element input
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] elem_data

    // kept element output
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] kept_data
    output logic              m_axis_tlast,   // tensor_done

    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // configuration registers
    t_cfg              r_dim [NUM_AXES];
    logic [AXIS_W-1:0] r_axis;
    t_cfg              r_begin;
    t_cfg              r_end;
    t_cfg              r_step;

    // tensor position state
    t_coord            r_coord [NUM_AXES];
    t_cfg              r_phase;

    // phase recompute control
    logic              r_cfg_wr;
    logic              r_busy;

    // output register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_last;

    logic              cfg_wr;
    t_reg_idx          reg_idx;
    logic              s_accept;

    logic [WIDE_W-1:0] eff_size [NUM_AXES];
    logic [WIDE_W-1:0] eff_step;
    logic [WIDE_W-1:0] c_wide;
    logic [WIDE_W-1:0] new_c_wide;
    logic [WIDE_W-1:0] begin_wide;
    logic [WIDE_W-1:0] phase_inc;
    logic [NUM_AXES-1:0] last;
    logic [NUM_AXES-1:0] carry_in;
    t_coord            n_coord [NUM_AXES];
    t_cfg              n_phase;
    logic              kept;
    logic              done;
    logic              carry;

    t_coord            rem_dividend;
    logic              rem_done;
    t_cfg              rem_value;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);

    // register readback
    always_comb begin
        case (reg_idx)
            REG_DIM_0: prdata = APB_DW'(r_dim[0]);
            REG_DIM_1: prdata = APB_DW'(r_dim[1]);
            REG_DIM_2: prdata = APB_DW'(r_dim[2]);
            REG_DIM_3: prdata = APB_DW'(r_dim[3]);
            REG_AXIS:  prdata = APB_DW'(r_axis);
            REG_BEGIN: prdata = APB_DW'(r_begin);
            REG_END:   prdata = APB_DW'(r_end);
            REG_STEP:  prdata = APB_DW'(r_step);
            default:   prdata = '0;
        endcase
    end

    // zero sizes and zero step behave as one
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            eff_size[a] = (r_dim[a] == '0) ? WIDE_W'(1) : WIDE_W'(r_dim[a]);
        end
        eff_step = (r_step == '0) ? WIDE_W'(1) : WIDE_W'(r_step);
    end

    assign begin_wide = WIDE_W'(r_begin);
    assign c_wide     = WIDE_W'(r_coord[r_axis]);

    // keep decision for the item at the head of the stream
    assign kept = (c_wide >= begin_wide) && (c_wide < WIDE_W'(r_end)) && (r_phase == '0);

    // row-major advance: an axis at or past its last position wraps and carries
    always_comb begin
        carry = 1'b1;
        for (int a = NUM_AXES - 1; a >= 0; a--) begin
            last[a]     = (WIDE_W'(r_coord[a]) + WIDE_W'(1)) >= eff_size[a];
            carry_in[a] = carry;
            if (carry) begin
                if (last[a]) begin
                    n_coord[a] = '0;
                end else begin
                    n_coord[a] = r_coord[a] + COORD_BITS'(1);
                    carry      = 1'b0;
                end
            end else begin
                n_coord[a] = r_coord[a];
            end
        end
    end

    assign done = &last;

    // step phase follows the sliced coordinate one increment at a time
    assign new_c_wide = WIDE_W'(n_coord[r_axis]);
    assign phase_inc  = WIDE_W'(r_phase) + WIDE_W'(1);

    always_comb begin
        if (!carry_in[r_axis]) begin
            n_phase = r_phase;
        end else if (new_c_wide <= begin_wide) begin
            n_phase = '0;
        end else if (phase_inc == eff_step) begin
            n_phase = '0;
        end else begin
            n_phase = phase_inc[CFG_W-1:0];
        end
    end

    // full recompute after a register write: (coord - begin) mod step
    assign rem_dividend = (c_wide >= begin_wide) ?
        COORD_BITS'(c_wide - begin_wide) : '0;

    sasf_remainder u_remainder (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_cfg_wr),
        .i_dividend (rem_dividend),
        .i_divisor  (eff_step[CFG_W-1:0]),
        .o_done     (rem_done),
        .o_rem      (rem_value)
    );

    // input is taken while no phase rebuild runs and the output register is free or draining
    assign s_axis_tready = !r_busy && (!r_out_valid || m_axis_tready);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_dim[a]   <= CFG_W'(1);
                r_coord[a] <= '0;
            end
            r_axis      <= AXIS_W'(NUM_AXES - 1);
            r_begin     <= '0;
            r_end       <= '1;
            r_step      <= CFG_W'(1);
            r_phase     <= '0;
            r_cfg_wr    <= 1'b0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cfg_wr <= cfg_wr;

            if (cfg_wr) begin
                r_busy <= 1'b1;
                case (reg_idx)
                    REG_DIM_0: r_dim[0] <= pwdata[CFG_W-1:0];
                    REG_DIM_1: r_dim[1] <= pwdata[CFG_W-1:0];
                    REG_DIM_2: r_dim[2] <= pwdata[CFG_W-1:0];
                    REG_DIM_3: r_dim[3] <= pwdata[CFG_W-1:0];
                    REG_AXIS:  r_axis   <= pwdata[AXIS_W-1:0];
                    REG_BEGIN: r_begin  <= pwdata[CFG_W-1:0];
                    REG_END:   r_end    <= pwdata[CFG_W-1:0];
                    REG_STEP:  r_step   <= pwdata[CFG_W-1:0];
                    default:   r_busy   <= 1'b1;
                endcase
            end else if (r_busy && rem_done && !r_cfg_wr) begin
                // a run started before a later write never lands here
                r_phase <= rem_value;
                r_busy  <= 1'b0;
            end

            if (s_accept) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    r_coord[a] <= n_coord[a];
                end
                r_phase <= n_phase;
            end

            if (s_accept && kept) begin
                r_out_valid <= 1'b1;
                r_out_data  <= s_axis_tdata & DATA_MASK;
                r_out_last  <= done;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // phase stays a proper residue whenever items may flow
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (WIDE_W'(r_phase) < eff_step))
        else $error("step phase not below step");

    // a register write holds off input until the phase is rebuilt
    a_wr_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> !s_axis_tready)
        else $error("input ready right after a register write");

    // last element of the tensor wraps every coordinate
    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && done) |=> ((r_coord[0] == '0) && (r_coord[1] == '0) &&
                                (r_coord[2] == '0) && (r_coord[3] == '0)))
        else $error("coordinates did not wrap after last element");

    // a kept item shows up on the output next cycle
    a_kept_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && kept) |=> m_axis_tvalid)
        else $error("kept item missing from output");

endmodule

### tb/strided_axis_slice_filter_tb.sv
`timescale 1ns / 100ps

module strided_axis_slice_filter_tb;
    import sasf_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 6;      // output is registered, leave some margin
    localparam int STALL_LIMIT   = 4000;   // cycles with no item, write or result moving
    localparam int LONG_HOLD     = 300;
    localparam int ITEM_TARGET   = 1500;   // random part stops here, the last phase follows
    localparam int LAST_PHASE    = 150;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // element stream in
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata  = '0;   // [31:0] elem_data

    // kept element stream out
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;         // [31:0] kept_data
    logic              m_axis_tlast;         // tensor_done

    // apb
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    strided_axis_slice_filter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // one expected output item
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              done;
    } t_kept_elem;

    t_kept_elem pending_kept[$];

    // shadow of the register file
    t_cfg          dim_cfg[NUM_AXES];
    logic [AXIS_W-1:0] axis_cfg;
    t_cfg          begin_cfg;
    t_cfg          end_cfg;
    t_cfg          step_cfg;

    // coordinate of the next element on each axis
    t_coord        pos[NUM_AXES];

    int  fail_cnt    = 0;
    int  items_sent  = 0;
    bit  tx_idle_on  = 1'b1;
    bit  rx_idle_on  = 1'b1;
    int  hold_req    = 0;   // bumped by a test to ask the receiver for a long hold-off

    task automatic reset_shadow();
        for (int a = 0; a < NUM_AXES; a++) begin
            dim_cfg[a] = 16'd1;
            pos[a]     = '0;
        end
        axis_cfg  = 2'd3;
        begin_cfg = 16'd0;
        end_cfg   = 16'hFFFF;
        step_cfg  = 16'd1;
    endtask

    task automatic shadow_reg_write(input t_reg_idx idx, input logic [APB_DW-1:0] v);
        case (idx)
            REG_DIM_0: dim_cfg[0] = v[CFG_W-1:0];
            REG_DIM_1: dim_cfg[1] = v[CFG_W-1:0];
            REG_DIM_2: dim_cfg[2] = v[CFG_W-1:0];
            REG_DIM_3: dim_cfg[3] = v[CFG_W-1:0];
            REG_AXIS:  axis_cfg   = v[AXIS_W-1:0];
            REG_BEGIN: begin_cfg  = v[CFG_W-1:0];
            REG_END:   end_cfg    = v[CFG_W-1:0];
            REG_STEP:  step_cfg   = v[CFG_W-1:0];
            default: ;
        endcase
    endtask

    // decides whether the element at the current coordinate is kept and whether it
    // closes the tensor, then advances the coordinates row-major
    task automatic classify_element(output logic keep, output logic done);
        t_coord            c;
        logic [CFG_W:0]    stride;
        logic [CFG_W:0]    sz;
        logic [NUM_AXES-1:0] last;
        logic              carry;
        c      = pos[axis_cfg];
        // zero step acts as one
        stride = (step_cfg == '0) ? 17'd1 : {1'b0, step_cfg};
        keep   = (c >= begin_cfg) && (c < end_cfg) &&
                 ((({1'b0, c} - {1'b0, begin_cfg}) % stride) == 0);
        for (int a = 0; a < NUM_AXES; a++) begin
            // zero size acts as one; a coordinate past its size counts as last
            sz      = (dim_cfg[a] == '0) ? 17'd1 : {1'b0, dim_cfg[a]};
            last[a] = ({1'b0, pos[a]} + 17'd1) >= sz;
        end
        done  = &last;
        carry = 1'b1;
        for (int a = NUM_AXES - 1; a >= 0; a--) begin
            if (carry) begin
                if (last[a]) begin
                    pos[a] = '0;
                end else begin
                    pos[a] = pos[a] + 1'b1;
                    carry  = 1'b0;
                end
            end
        end
    endtask

    // monitor: predicts on every accepted input item, checks every output item
    always @(posedge i_clk) begin : monitor
        logic       keep;
        logic       done;
        t_kept_elem want;
        if (!i_rst_n) begin
            reset_shadow();
            pending_kept.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_kept.size() == 0) begin
                    $error("unexpected output item: kept_data %h tensor_done %b",
                           m_axis_tdata, m_axis_tlast);
                    fail_cnt++;
                end else begin
                    want = pending_kept.pop_front();
                    if (m_axis_tdata !== want.data) begin
                        $error("kept_data mismatch: expected %h, actual %h",
                               want.data, m_axis_tdata);
                        fail_cnt++;
                    end
                    if (m_axis_tlast !== want.done) begin
                        $error("tensor_done mismatch: expected %b, actual %b",
                               want.done, m_axis_tlast);
                        fail_cnt++;
                    end
                end
            end
            // registers only change while no element is in flight
            if (psel && penable && pwrite && pready)
                shadow_reg_write(t_reg_idx'(paddr[4:2]), pwdata);
            if (s_axis_tvalid && s_axis_tready) begin
                classify_element(keep, done);
                if (keep) begin
                    want = '{data: s_axis_tdata & DATA_MASK, done: done};
                    pending_kept.insert(pending_kept.size(), want);
                end
            end
        end
    end

    // watchdog on cycles where nothing moves
    always @(posedge i_clk) begin : watchdog
        int quiet;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("strided_axis_slice_filter verification failed");
            $finish;
        end
    end

    // receiver: random idle bursts, plus one long hold-off on request
    always @(negedge i_clk) begin : receiver
        int hold_left;
        int hold_seen;
        if (hold_seen != hold_req) begin
            hold_seen     = hold_req;
            hold_left     = LONG_HOLD - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            hold_left     = $urandom_range(1, 14) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // offers one element and returns once it is taken
    task automatic send_item(input logic [DATA_W-1:0] d);
        @(negedge i_clk);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do
            @(posedge i_clk);
        while (!(s_axis_tvalid && s_axis_tready));
        items_sent++;
    endtask

    // lowers valid and waits until every kept element has come out
    task automatic wait_drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_kept.size() != 0) @(negedge i_clk);
        // a dropped element may still be in the pipe
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // apb write: setup then access; upper bits sometimes carry noise
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] val);
        logic [31:0] noise;
        noise = $urandom;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(int'(idx) * 4);
        pwdata  <= ($urandom_range(0, 3) == 0) ? {noise[31:16], val} : {16'h0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_shape(input logic [CFG_W-1:0] d0, input logic [CFG_W-1:0] d1,
                               input logic [CFG_W-1:0] d2, input logic [CFG_W-1:0] d3,
                               input logic [1:0] ax, input logic [CFG_W-1:0] b,
                               input logic [CFG_W-1:0] e, input logic [CFG_W-1:0] st);
        write_reg(REG_DIM_0, d0);
        write_reg(REG_DIM_1, d1);
        write_reg(REG_DIM_2, d2);
        write_reg(REG_DIM_3, d3);
        write_reg(REG_AXIS,  {14'h0, ax});
        write_reg(REG_BEGIN, b);
        write_reg(REG_END,   e);
        write_reg(REG_STEP,  st);
    endtask

    function automatic logic [DATA_W-1:0] random_elem();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // picks a random tensor shape and slice, mostly small so tensors complete often
    task automatic program_random_slice();
        logic [CFG_W-1:0] dims[NUM_AXES];
        logic [1:0]       ax;
        logic [CFG_W-1:0] b;
        logic [CFG_W-1:0] e;
        logic [CFG_W-1:0] st;
        int               rank;
        rank = $urandom_range(1, 4);
        for (int a = 0; a < NUM_AXES; a++)
            dims[a] = (a < NUM_AXES - rank) ? 16'd1 : 16'($urandom_range(1, 5));
        case ($urandom_range(0, 15))
            0:       dims[$urandom_range(0, 3)] = 16'($urandom_range(1, 65535));
            1:       dims[$urandom_range(0, 3)] = 16'd0;
            2:       dims[$urandom_range(0, 3)] = 16'hFFFF;
            default: ;
        endcase
        ax = 2'($urandom_range(0, 3));
        b  = 16'($urandom_range(0, (dims[ax] > 6) ? 6 : dims[ax]));
        e  = b + 16'($urandom_range(1, 6));
        st = 16'($urandom_range(1, 3));
        case ($urandom_range(0, 15))
            0: begin
                b = 16'd0;
                e = 16'hFFFF;
            end
            1: e = b - 16'($urandom_range(0, 2));   // empty slice
            2: st = 16'd0;
            3: st = 16'hFFFF;
            4: begin
                b  = 16'($urandom);
                e  = 16'($urandom);
                st = 16'($urandom);
            end
            5: begin
                b = 16'hFFFF;
                e = 16'hFFFF;
            end
            default: ;
        endcase
        write_shape(dims[0], dims[1], dims[2], dims[3], ax, b, e, st);
    endtask

    // reset values: every element is its own tensor and is kept
    task automatic test_reset_values();
        send_item(32'h0000_0000);
        send_item(32'hFFFF_FFFF);
        send_item(32'hAAAA_AAAA);
        send_item(32'h5555_5555);
        wait_drain();
    endtask

    // zero sizes and zero step act as one; end at or below begin keeps nothing
    task automatic test_degenerate_registers();
        write_shape(16'd0, 16'd0, 16'd0, 16'd0, 2'd3, 16'd0, 16'hFFFF, 16'd0);
        repeat (3) send_item(random_elem());
        wait_drain();
        write_reg(REG_END, 16'd0);
        repeat (2) send_item(random_elem());
        wait_drain();
        write_reg(REG_BEGIN, 16'd7);
        write_reg(REG_END,   16'd5);
        repeat (2) send_item(random_elem());
        wait_drain();
    endtask

    // strided slice on an outer axis, last element dropped so no tensor_done shows
    task automatic test_dropped_last();
        write_shape(16'd1, 16'd3, 16'd1, 16'd2, 2'd1, 16'd1, 16'd3, 16'd2);
        repeat (6) send_item(random_elem());
        wait_drain();
        // outermost axis, last element kept and marked
        write_shape(16'd3, 16'd1, 16'd1, 16'd1, 2'd0, 16'd0, 16'd3, 16'd2);
        repeat (3) send_item(random_elem());
        wait_drain();
    endtask

    // shrinking a size mid-tensor leaves the coordinate past the end; it wraps next
    task automatic test_size_shrink();
        write_shape(16'd1, 16'd1, 16'd1, 16'd4, 2'd3, 16'd0, 16'hFFFF, 16'd1);
        repeat (2) send_item(random_elem());
        wait_drain();
        write_reg(REG_DIM_3, 16'd2);
        repeat (2) send_item(random_elem());
        wait_drain();
        // largest sizes everywhere
        write_shape(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd2, 16'd0, 16'd1, 16'hFFFF);
        repeat (2) send_item(random_elem());
        wait_drain();
    endtask

    // many random settings, idling switched per phase
    task automatic test_random_slices();
        int n;
        while (items_sent < ITEM_TARGET) begin
            program_random_slice();
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            n = $urandom_range(10, 120);
            repeat (n) send_item(random_elem());
            wait_drain();
        end
    endtask

    // receiver holds off long while elements keep coming, input must stall
    task automatic test_output_stall();
        write_shape(16'd1, 16'd1, 16'd2, 16'd3, 2'd3, 16'd0, 16'hFFFF, 16'd1);
        tx_idle_on = 1'b0;
        @(negedge i_clk);
        hold_req++;
        repeat (40) send_item(random_elem());
        wait_drain();
    endtask

    // closing stretch without any idling
    task automatic test_full_rate();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        program_random_slice();
        repeat (LAST_PHASE) send_item(random_elem());
        wait_drain();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_values();
        test_degenerate_registers();
        test_dropped_last();
        test_size_shrink();
        test_random_slices();
        test_output_stall();
        test_full_rate();

        repeat (20) @(negedge i_clk);
        if (fail_cnt == 0 && pending_kept.size() == 0)
            $display("strided_axis_slice_filter verification clean");
        else
            $display("strided_axis_slice_filter verification failed");
        $finish;
    end

endmodule
